// File: hdl/bmlsu_pkg.sv
// Shared types and constants of the byte memory load/store unit.
package bmlsu_pkg;

	localparam int MEM_BYTES = 65536;
	localparam int NUM_BANKS = 4;
	localparam int ADDR_W = $clog2(MEM_BYTES);
	localparam int BANK_ROWS = MEM_BYTES / NUM_BANKS;
	localparam int ROW_W = $clog2(BANK_ROWS);
	localparam int QUEUE_DEPTH = 2;

	localparam logic [2:0] REQ_LB  = 3'd0;
	localparam logic [2:0] REQ_LBU = 3'd1;
	localparam logic [2:0] REQ_LH  = 3'd2;
	localparam logic [2:0] REQ_LHU = 3'd3;
	localparam logic [2:0] REQ_LW  = 3'd4;
	localparam logic [2:0] REQ_SB  = 3'd5;
	localparam logic [2:0] REQ_SH  = 3'd6;
	localparam logic [2:0] REQ_SW  = 3'd7;

	// Index of the last byte lane used by an access.
	localparam logic [1:0] LAST_BYTE = 2'd0;
	localparam logic [1:0] LAST_HALF = 2'd1;
	localparam logic [1:0] LAST_WORD = 2'd3;

	typedef struct packed {
		logic                                store;
		logic                                sign;
		logic [1:0]                          last;
		logic [1:0]                          offset;
		logic [NUM_BANKS-1:0]                lane_mask;
		logic [NUM_BANKS-1:0][ROW_W-1:0]     rows;
		logic [NUM_BANKS-1:0][7:0]           lane_data;
		logic [31:0]                         tag;
	} req_t;

endpackage

// File: hdl/bmlsu_front.sv
// Front end: accepts requests and splits them into per-bank rows, lanes and data.
module bmlsu_front (
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [2:0]        req_type,
	input  logic [15:0]       address,
	input  logic [31:0]       operand,
	input  logic              clear_busy,
	input  logic              q_full,
	output logic              push,
	output bmlsu_pkg::req_t   push_data
);
	import bmlsu_pkg::*;

	logic [ADDR_W-1:0] base;
	logic [1:0]        off;
	logic [1:0]        last;
	logic [1:0]        lane_k [NUM_BANKS];

	assign req_stall = q_full || clear_busy;
	assign push = req_valid && !req_stall;
	assign base = ADDR_W'(address);
	assign off = base[1:0];

	always_comb begin
		unique case (req_type) inside
			REQ_LB, REQ_LBU, REQ_SB: last = LAST_BYTE;
			REQ_LH, REQ_LHU, REQ_SH: last = LAST_HALF;
			REQ_LW, REQ_SW:          last = LAST_WORD;
			default:                 last = LAST_WORD;
		endcase
	end

	always_comb begin
		push_data.store = (req_type == REQ_SB) || (req_type == REQ_SH) || (req_type == REQ_SW);
		push_data.sign = (req_type == REQ_LB) || (req_type == REQ_LH);
		push_data.last = last;
		push_data.offset = off;
		push_data.tag = operand;
		for (int j = 0; j < NUM_BANKS; j++) begin
			// Bank j holds byte k of the access, where k counts up from the offset.
			lane_k[j] = 2'(j) - off;
			push_data.lane_mask[j] = (lane_k[j] <= last);
			push_data.lane_data[j] = operand[8*lane_k[j] +: 8];
			push_data.rows[j] = base[ADDR_W-1:2] + ROW_W'(2'(j) < off);
		end
	end

endmodule

// File: hdl/bmlsu_queue.sv
// Two-entry request queue between the front end and the memory back end.
module bmlsu_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bmlsu_pkg::req_t   push_data,
	input  logic              pop,
	output logic              q_valid,
	output logic              q_full,
	output bmlsu_pkg::req_t   head
);
	import bmlsu_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	req_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_valid = (count_q != '0);
	assign q_full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: hdl/bmlsu_back.sv
// Back end: four byte banks, the clearing pass, load read and result formatting.
module bmlsu_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  bmlsu_pkg::req_t   head,
	output logic              pop,
	output logic              clear_busy,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [31:0]       load_tag,
	output logic signed [31:0] load_data
);
	import bmlsu_pkg::*;

	logic [7:0]       bank_q [NUM_BANKS][BANK_ROWS];
	logic [7:0]       rdata_s1 [NUM_BANKS];
	logic             valid_s1;
	logic             sign_s1;
	logic [1:0]       last_s1;
	logic [1:0]       offset_s1;
	logic [31:0]      tag_s1;
	logic             clr_busy_q;
	logic [ROW_W-1:0] clr_row_q;
	logic             out_valid_q;
	logic [31:0]      out_tag_q;
	logic [31:0]      out_data_q;
	logic             out_free;
	logic             load_pop;
	logic [7:0]       b [4];
	logic [31:0]      fmt;

	assign clear_busy = clr_busy_q;
	assign out_free = !out_valid_q || !rsp_stall;
	// A store finishes at its write; a load needs the read stage to be free or moving.
	assign pop = q_valid && !clr_busy_q && (head.store || !valid_s1 || out_free);
	assign load_pop = pop && !head.store;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q <= '0;
		end else if (clr_busy_q) begin
			clr_row_q <= clr_row_q + 1'b1;
			if (clr_row_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	for (genvar j = 0; j < NUM_BANKS; j++) begin : g_bank
		always_ff @(posedge clk) begin
			if (clr_busy_q) begin
				bank_q[j][clr_row_q] <= 8'h00;
			end else if (pop && head.store && head.lane_mask[j]) begin
				bank_q[j][head.rows[j]] <= head.lane_data[j];
			end
			if (load_pop) begin
				rdata_s1[j] <= bank_q[j][head.rows[j]];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_pop) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_pop) begin
			sign_s1 <= head.sign;
			last_s1 <= head.last;
			offset_s1 <= head.offset;
			tag_s1 <= head.tag;
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			b[k] = rdata_s1[2'(k) + offset_s1];
		end
		unique case (last_s1)
			LAST_BYTE: fmt = {{24{sign_s1 & b[0][7]}}, b[0]};
			LAST_HALF: fmt = {{16{sign_s1 & b[1][7]}}, b[1], b[0]};
			default:   fmt = {b[3], b[2], b[1], b[0]};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			out_tag_q <= tag_s1;
			out_data_q <= fmt;
		end
	end

	assign rsp_valid = out_valid_q;
	assign load_tag = out_tag_q;
	assign load_data = $signed(out_data_q);

	a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !pop)
		else $error("request issued during the clearing pass");

	a_load_enters_read_stage: assert property (@(posedge clk) disable iff (!arst_n)
		load_pop |=> valid_s1)
		else $error("issued load did not reach the read stage");

	a_read_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(tag_s1))
		else $error("stalled load lost from the read stage");

	a_result_from_read_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result appeared without a load in the read stage");

endmodule

// File: hdl/byte_memory_load_store_unit.sv
// Top level of the byte-addressed little-endian load/store unit.
//
// Usage: the request channel (req_valid, req_stall, req_type, address, operand)
// takes one LB, LBU, LH, LHU, LW, SB, SH or SW per transfer. For a store the
// operand is the data and no response follows. For a load the operand is a tag,
// and one response transfer (rsp_valid, rsp_stall, load_tag, load_data) returns
// that tag with the loaded value, sign- or zero-extended by load kind.
// Unaligned accesses are allowed; byte addresses wrap at the memory size.
// The memory is four byte-wide banks; an access uses each bank at most once.
// Throughput is one request per cycle while req_stall is low. A load passes
// through the queue, the bank read stage and the output register before its
// response is valid. Requests are served strictly in order.
// After reset the banks are cleared one row per cycle, 16384 rows in all, and
// req_stall stays high during that pass. When the receiver stalls, the
// output register and the read stage hold, the two-entry queue fills, and then
// req_stall rises. Stores keep draining past a stalled load.
module byte_memory_load_store_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         req_type,
	input  logic [15:0]        address,
	input  logic [31:0]        operand,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [31:0]        load_tag,
	output logic signed [31:0] load_data
);
	import bmlsu_pkg::*;

	logic push;
	req_t push_data;
	logic pop;
	logic q_valid;
	logic q_full;
	req_t head;
	logic clear_busy;

	// Decode and lane steering of incoming requests.
	bmlsu_front u_front (
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_type   (req_type),
		.address    (address),
		.operand    (operand),
		.clear_busy (clear_busy),
		.q_full     (q_full),
		.push       (push),
		.push_data  (push_data)
	);

	// Short queue that lets the front and the banks stall independently.
	bmlsu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_full    (q_full),
		.head      (head)
	);

	// Banks, read stage and the response register.
	bmlsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.head       (head),
		.pop        (pop),
		.clear_busy (clear_busy),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.load_tag   (load_tag),
		.load_data  (load_data)
	);

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the byte memory load/store unit.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bmlsu_pkg::*;

	// One expected load response: the echoed tag and the extended data.
	typedef struct packed {
		logic [31:0] tag;
		logic [31:0] data;
	} load_result_t;

	// Byte-accurate mirror of the data memory. Every accepted request is applied
	// to it in order. Loads push the response they must produce onto a queue, and
	// each response transfer from the block is checked against the oldest entry.
	class memory_mirror;
		bit [7:0]     bytes [MEM_BYTES];
		load_result_t pending_loads [$];
		int           errors;
		int           loads_checked;
		int           stores_seen;

		function void note_request(logic [2:0] kind, logic [15:0] addr, logic [31:0] opnd);
			logic [31:0]  word;
			int           nbytes;
			load_result_t result;
			word = '0;
			case (kind)
				REQ_LB, REQ_LBU, REQ_SB: nbytes = 1;
				REQ_LH, REQ_LHU, REQ_SH: nbytes = 2;
				default:                 nbytes = 4;
			endcase
			if (kind == REQ_SB || kind == REQ_SH || kind == REQ_SW) begin
				// Little-endian: the least significant byte goes to the lowest address,
				// and every byte address wraps at the top of memory.
				for (int k = 0; k < nbytes; k++)
					bytes[(int'(addr) + k) % MEM_BYTES] = opnd[8*k +: 8];
				stores_seen++;
			end else begin
				for (int k = 0; k < nbytes; k++)
					word[8*k +: 8] = bytes[(int'(addr) + k) % MEM_BYTES];
				if (kind == REQ_LB)
					word = {{24{word[7]}}, word[7:0]};
				else if (kind == REQ_LH)
					word = {{16{word[15]}}, word[15:0]};
				result.tag  = opnd;
				result.data = word;
				pending_loads.push_back(result);
			end
		endfunction

		function int unsigned pending();
			return pending_loads.size();
		endfunction

		function void check_load_result(logic [31:0] tag, logic [31:0] data);
			load_result_t want;
			if (pending_loads.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: unexpected load response tag=%h data=%h", tag, data);
				return;
			end
			want = pending_loads.pop_front();
			loads_checked++;
			if (tag !== want.tag) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: load_tag expected %h, got %h", want.tag, tag);
			end
			if (data !== want.data) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: load_data for tag %h expected %h, got %h",
						want.tag, want.data, data);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [2:0]         req_type = REQ_LB;
	logic [15:0]        address = '0;
	logic [31:0]        operand = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [31:0]        load_tag;
	logic signed [31:0] load_data;

	// Idling switches: when set, the side draws a random wait for every item.
	bit req_idle_on = 1'b1;
	bit rsp_idle_on = 1'b1;

	memory_mirror mirror = new();

	byte_memory_load_store_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.address   (address),
		.operand   (operand),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.load_tag  (load_tag),
		.load_data (load_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Drive one request and hold it until the block takes the transfer. With a
	// zero gap, valid stays high from the previous transfer, so back-to-back
	// requests go out at full rate. The mirror is updated at the accepting edge.
	task automatic issue_request(input logic [2:0] kind, input logic [15:0] addr,
		input logic [31:0] opnd);
		int unsigned gap;
		gap = req_idle_on ? $urandom_range(0, 11) : 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= kind;
		address   <= addr;
		operand   <= opnd;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		mirror.note_request(kind, addr, opnd);
	endtask

	// Stop sending and wait until every load issued so far has answered.
	task automatic hold_until_drained();
		req_valid <= 1'b0;
		while (mirror.pending() != 0) @(posedge clk);
	endtask

	// Response checker. Outputs are read right at the rising edge, so they hold
	// the values from before the edge, exactly what the block presented.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			mirror.check_load_result(load_tag, load_data);
	end

	// Response sink. After every response transfer it draws a stall length; a
	// zero draw, or a phase with idling off, leaves the channel open.
	initial begin : response_sink
		int unsigned hold;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				hold = rsp_idle_on ? $urandom_range(0, 11) : 0;
				if (hold != 0) begin
					rsp_stall <= 1'b1;
					repeat (hold) @(posedge clk);
					rsp_stall <= 1'b0;
				end
			end
		end
	end

	// Watchdog. The slowest correct run, including the clearing pass of the
	// banks after reset, stays below a fifth of this.
	initial begin : watchdog
		#400_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		logic [2:0]  kind;
		logic [15:0] addr;
		logic [31:0] opnd;
		logic [15:0] recent_stores [$];
		int unsigned pick;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. The memory was cleared at reset, so a first word read
		// returns zero. A word store at the last address wraps its upper three
		// bytes to addresses 0 to 2; the reads below check sign- and zero-extension
		// of bytes and halfwords after the wrap, and reads that start at the last address.
		issue_request(REQ_LW,  16'h0000, 32'hFFFF_FFFF);
		issue_request(REQ_SW,  16'hFFFF, 32'h80FF_7F01);
		issue_request(REQ_LW,  16'hFFFF, 32'h0000_0000);
		issue_request(REQ_LB,  16'hFFFF, 32'h0000_0001);
		issue_request(REQ_LB,  16'h0000, 32'h0000_0002);
		issue_request(REQ_LBU, 16'h0000, 32'h0000_0003);
		issue_request(REQ_LB,  16'h0001, 32'h8000_0000);
		issue_request(REQ_LBU, 16'h0001, 32'h8000_0001);
		issue_request(REQ_LH,  16'h0001, 32'h7FFF_FFFF);
		issue_request(REQ_LHU, 16'h0001, 32'hA5A5_A5A5);
		issue_request(REQ_LH,  16'hFFFF, 32'h5A5A_5A5A);
		// A halfword store that straddles the top of memory, read back both ways.
		issue_request(REQ_SH,  16'hFFFF, 32'h1234_8001);
		issue_request(REQ_LHU, 16'hFFFF, 32'h0000_0010);
		issue_request(REQ_LH,  16'hFFFF, 32'h0000_0011);
		// A byte store keeps only the low byte of an all-ones-above operand.
		issue_request(REQ_SB,  16'h8000, 32'hFFFF_FF80);
		issue_request(REQ_LB,  16'h8000, 32'h0000_0020);
		issue_request(REQ_LBU, 16'h8000, 32'h0000_0021);
		issue_request(REQ_LW,  16'h7FFF, 32'h0000_0022);
		// Unaligned word in the middle of memory, read at several offsets.
		issue_request(REQ_SW,  16'h1235, 32'hDEAD_BEEF);
		issue_request(REQ_LW,  16'h1235, 32'h0000_0030);
		issue_request(REQ_LH,  16'h1236, 32'h0000_0031);
		issue_request(REQ_LW,  16'h1234, 32'h0000_0032);
		issue_request(REQ_SW,  16'h0000, 32'h0000_0000);
		issue_request(REQ_LW,  16'hFFFE, 32'hFFFF_FFFF);
		hold_until_drained();

		// Random part in four phases: both sides idling, full rate on both sides,
		// a full-rate sender against a stalling receiver so that the request
		// queue fills and back-pressure reaches the sender, and the reverse.
		// Addresses cluster around recent stores and both ends of memory, so
		// most loads read back data that was written, often across the wrap.
		for (int phase = 0; phase < 4; phase++) begin
			req_idle_on = (phase == 0) || (phase == 3);
			rsp_idle_on = (phase == 0) || (phase == 2);
			for (int n = 0; n < 120; n++) begin
				kind = 3'($urandom_range(0, 7));
				pick = $urandom_range(0, 9);
				if (pick < 4 && recent_stores.size() != 0)
					addr = recent_stores[$urandom_range(0, recent_stores.size() - 1)]
						+ 16'($urandom_range(0, 4)) - 16'd1;
				else if (pick < 7)
					addr = ($urandom_range(0, 1) ? 16'hFFF0 : 16'h0000)
						| 16'($urandom_range(0, 15));
				else
					addr = 16'($urandom);
				opnd = $urandom;
				if ($urandom_range(0, 7) == 0)
					opnd = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
				if (kind == REQ_SB || kind == REQ_SH || kind == REQ_SW) begin
					recent_stores.push_back(addr);
					if (recent_stores.size() > 16)
						void'(recent_stores.pop_front());
				end
				issue_request(kind, addr, opnd);
			end
			// Once mid-run, the sender stops until every load has answered.
			if (phase == 1)
				hold_until_drained();
		end

		hold_until_drained();
		repeat (20) @(posedge clk);

		$display("Covered %0d transfers: %0d stores and %0d loads checked against the byte mirror,",
			mirror.stores_seen + mirror.loads_checked, mirror.stores_seen, mirror.loads_checked);
		$display("with wrapping and unaligned accesses under idle, full-rate and stalled phases.");
		if (mirror.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches in total.", mirror.errors);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
